// ===== hdl/mkaf_pkg.sv =====
// ---------------------------------------------------------------------------
// mkaf_pkg - shared types and constants for the keypad scanner
// Action codes, sequencer states, register indexes and the power-up code
// table of the 4x4 keypad.
// ---------------------------------------------------------------------------
package mkaf_pkg;

  typedef enum logic [1:0] {
    ACT_SCAN  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PUSH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    REG_TABLE_ENTRIES = 2'd0,
    REG_FIRST_DELAY   = 2'd1,
    REG_REPEAT_DELAY  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  localparam logic [15:0] COL_FLIP      = 16'h8888;
  localparam logic [5:0]  RST_ENTRIES   = 6'd16;
  localparam logic [15:0] RST_FIRST     = 16'd20;
  localparam logic [15:0] RST_REPEAT    = 16'd2;
  localparam int          DEFAULT_KEYS  = 16;

  // bit k of the pattern maps to this character
  localparam logic [7:0] DEF_SYM [DEFAULT_KEYS] = '{
    8'h64, 8'h63, 8'h61, 8'h62, 8'h0A, 8'h39, 8'h33, 8'h36,
    8'h30, 8'h38, 8'h32, 8'h35, 8'h2A, 8'h37, 8'h31, 8'h34
  };

  // power-up content of a table entry: {pattern, symbol}
  function automatic logic [23:0] def_entry(input logic [7:0] idx);
    logic [23:0] e;
    e = '0;
    if (idx < 8'(DEFAULT_KEYS)) begin
      e = {16'(17'd1 << idx[3:0]), DEF_SYM[idx[3:0]]};
    end
    return e;
  endfunction

endpackage

// ===== hdl/matrix_keypad_autorepeat_fifo.sv =====
// ---------------------------------------------------------------------------
// matrix_keypad_autorepeat_fifo - 4x4 keypad scanner, typematic repeat, FIFO
// Decodes sampled column nibbles into a key pattern, looks it up in a
// loadable code table and queues the characters in a circular FIFO.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) takes one word per action: a scan tick
//   with four column nibbles, a read that pops one character, or a write of
//   one code table entry. Every input word yields exactly one output word on
//   out_valid/out_ready carrying the key pattern, make/drop flags, the
//   popped character and the FIFO fill level.
//   Timing: a scan tick that needs a lookup walks the table one entry a
//   cycle through the table RAM port; other words pass through the done
//   state into the output register. One word is worked on at a time.
//   A finished word sits in the output register; the next input word is
//   accepted meanwhile, and only its completion waits if out_ready is low.
//   Reset (rst_n low, synchronous) restores the default 16-key table through
//   per-entry valid bits, clears the repeat state and empties the FIFO.
//   No clearing pass is needed. Register writes (APB) are only to be made idle;
//   not enforced. FIFO holds FIFO_DEPTH-1 characters; further ones are dropped.
// ---------------------------------------------------------------------------
module matrix_keypad_autorepeat_fifo #(
  parameter int TABLE_SIZE = 32,
  parameter int FIFO_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_column_samples,
  input  logic [4:0]  in_entry_index,
  input  logic [15:0] in_entry_pattern,
  input  logic [7:0]  in_entry_symbol,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_key_pattern,
  output logic        out_symbol_made,
  output logic        out_symbol_dropped,
  output logic        out_read_valid,
  output logic [7:0]  out_read_symbol,
  output logic [5:0]  out_fill_level,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;  // table address
  localparam int CW = $clog2(TABLE_SIZE + 1);                     // search counter
  localparam int FW = $clog2(FIFO_DEPTH);                         // fifo pointers

  // ------------------------------------------------------------------
  // register port
  // ------------------------------------------------------------------
  logic [5:0]  te_r;
  logic [15:0] fd_r;
  logic [15:0] rd_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      te_r <= mkaf_pkg::RST_ENTRIES;
      fd_r <= mkaf_pkg::RST_FIRST;
      rd_r <= mkaf_pkg::RST_REPEAT;
    end else if (cfg_wr) begin
      unique case (mkaf_pkg::reg_idx_t'(paddr[3:2]))
        mkaf_pkg::REG_TABLE_ENTRIES: te_r <= pwdata[5:0];
        mkaf_pkg::REG_FIRST_DELAY:   fd_r <= pwdata[15:0];
        mkaf_pkg::REG_REPEAT_DELAY:  rd_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mkaf_pkg::reg_idx_t'(paddr[3:2]))
      mkaf_pkg::REG_TABLE_ENTRIES: prdata = 32'(te_r);
      mkaf_pkg::REG_FIRST_DELAY:   prdata = 32'(fd_r);
      mkaf_pkg::REG_REPEAT_DELAY:  prdata = 32'(rd_r);
      default:                     prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // state
  // ------------------------------------------------------------------
  mkaf_pkg::state_t state_r, state_nxt;

  logic [15:0]           prev_r, prev_nxt;
  logic [15:0]           cd_r, cd_nxt;
  logic [15:0]           pat_r, pat_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [7:0]            sym_r, sym_nxt;
  logic                  made_r, made_nxt;
  logic                  drop_r, drop_nxt;
  logic                  rv_r, rv_nxt;
  logic [FW-1:0]         head_r, head_nxt;
  logic [FW-1:0]         tail_r, tail_nxt;
  logic [FW-1:0]         cnt_r, cnt_nxt;
  logic [TABLE_SIZE-1:0] tvld_r;

  logic        out_valid_r;
  logic [15:0] out_key_pattern_r;
  logic        out_symbol_made_r;
  logic        out_symbol_dropped_r;
  logic        out_read_valid_r;
  logic [7:0]  out_read_symbol_r;
  logic [5:0]  out_fill_level_r;

  // ------------------------------------------------------------------
  // code table RAM: {pattern, symbol}, valid bit per entry
  // ------------------------------------------------------------------
  logic [23:0]   tbl_mem [TABLE_SIZE];
  logic [23:0]   tbl_q;
  logic [TW-1:0] tbl_addr_q;
  logic          tbl_vld_q;
  logic          tbl_re, tbl_we;
  logic [TW-1:0] tbl_raddr, tbl_waddr;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= {in_entry_pattern, in_entry_symbol};
    end
    if (tbl_re) begin
      tbl_q      <= tbl_mem[tbl_raddr];
      tbl_addr_q <= tbl_raddr;
      tbl_vld_q  <= tvld_r[tbl_raddr];
    end
  end

  // ------------------------------------------------------------------
  // character FIFO RAM
  // ------------------------------------------------------------------
  logic [7:0] fifo_mem [FIFO_DEPTH];
  logic [7:0] fifo_q;
  logic       fifo_re, fifo_we;

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= sym_r;
    end
    if (fifo_re) begin
      fifo_q <= fifo_mem[head_r];
    end
  end

  // ------------------------------------------------------------------
  // helpers
  // ------------------------------------------------------------------
  logic                  in_fire, out_free;
  mkaf_pkg::action_t     act;
  logic [15:0]           scan_pat;
  logic                  scan_new, scan_rep, scan_need;
  logic [31:0]           te_ext, lim_ext;
  logic [CW-1:0]         lim;
  logic [23:0]           entry;
  logic                  match;
  logic                  search_end;
  logic                  wr_ok;
  logic                  fifo_room;
  logic [FW-1:0]         head_inc, tail_inc;

  assign in_ready  = (state_r == mkaf_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign act       = mkaf_pkg::action_t'(in_action);

  // active-low column bits, bit 3 of each nibble already inverted by the port
  assign scan_pat  = ~(in_column_samples ^ mkaf_pkg::COL_FLIP);
  assign scan_new  = (scan_pat != 16'd0) && (scan_pat != prev_r);
  assign scan_rep  = (scan_pat != 16'd0) && (scan_pat == prev_r) && (cd_r <= 16'd1);
  assign scan_need = scan_new || scan_rep;

  // search length saturates at the table size
  assign te_ext  = 32'(te_r);
  assign lim_ext = (te_ext > 32'(TABLE_SIZE)) ? 32'(TABLE_SIZE) : te_ext;
  assign lim     = lim_ext[CW-1:0];

  // unwritten entries read as their power-up value
  assign entry      = tbl_vld_q ? tbl_q : mkaf_pkg::def_entry(8'(tbl_addr_q));
  assign match      = pend_r && (entry[23:8] == pat_r);
  assign search_end = match || (idx_r >= lim);

  assign wr_ok     = 32'(in_entry_index) < 32'(TABLE_SIZE);
  assign fifo_room = 32'(cnt_r) < 32'(FIFO_DEPTH - 1);
  assign head_inc  = (32'(head_r) == 32'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (32'(tail_r) == 32'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // ------------------------------------------------------------------
  // sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mkaf_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((act == mkaf_pkg::ACT_SCAN) && scan_need) begin
            state_nxt = mkaf_pkg::S_SEARCH;
          end else begin
            state_nxt = mkaf_pkg::S_DONE;
          end
        end
      end
      mkaf_pkg::S_SEARCH: begin
        if (search_end) begin
          state_nxt = mkaf_pkg::S_PUSH;
        end
      end
      mkaf_pkg::S_PUSH: state_nxt = mkaf_pkg::S_DONE;
      mkaf_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mkaf_pkg::S_IDLE;
        end
      end
      default: state_nxt = mkaf_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer: datapath and memory control
  // ------------------------------------------------------------------
  always_comb begin
    prev_nxt  = prev_r;
    cd_nxt    = cd_r;
    pat_nxt   = pat_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    sym_nxt   = sym_r;
    made_nxt  = made_r;
    drop_nxt  = drop_r;
    rv_nxt    = rv_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    tbl_re    = 1'b0;
    tbl_raddr = idx_r[TW-1:0];
    tbl_we    = 1'b0;
    tbl_waddr = TW'(in_entry_index);
    fifo_re   = 1'b0;
    fifo_we   = 1'b0;

    unique case (state_r)
      mkaf_pkg::S_IDLE: begin
        if (in_fire) begin
          made_nxt = 1'b0;
          drop_nxt = 1'b0;
          rv_nxt   = 1'b0;
          case (act)
            mkaf_pkg::ACT_SCAN: begin
              prev_nxt = scan_pat;
              pat_nxt  = scan_pat;
              idx_nxt  = '0;
              pend_nxt = 1'b0;
              sym_nxt  = '0;
              if (scan_new) begin
                cd_nxt = fd_r;
              end else if (scan_rep) begin
                cd_nxt = rd_r;
              end else if (scan_pat != 16'd0) begin
                cd_nxt = cd_r - 16'd1;
              end
            end
            mkaf_pkg::ACT_READ: begin
              if (cnt_r != '0) begin
                rv_nxt   = 1'b1;
                fifo_re  = 1'b1;
                head_nxt = head_inc;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            mkaf_pkg::ACT_WRITE: begin
              tbl_we = wr_ok;
            end
            default: ;
          endcase
        end
      end
      mkaf_pkg::S_SEARCH: begin
        // compare the entry read last cycle while fetching the next one
        if (match) begin
          sym_nxt = entry[7:0];
        end else if (idx_r < lim) begin
          tbl_re   = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
      end
      mkaf_pkg::S_PUSH: begin
        if (sym_r != 8'd0) begin
          made_nxt = 1'b1;
          if (fifo_room) begin
            fifo_we  = 1'b1;
            tail_nxt = tail_inc;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      mkaf_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mkaf_pkg::S_IDLE;
      prev_r      <= '0;
      cd_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      tvld_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      cd_r    <= cd_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (tbl_we) begin
        tvld_r[tbl_waddr] <= 1'b1;
      end
      if ((state_r == mkaf_pkg::S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    idx_r  <= idx_nxt;
    sym_r  <= sym_nxt;
    made_r <= made_nxt;
    drop_r <= drop_nxt;
    rv_r   <= rv_nxt;
    if ((state_r == mkaf_pkg::S_DONE) && out_free) begin
      out_key_pattern_r    <= prev_r;
      out_symbol_made_r    <= made_r;
      out_symbol_dropped_r <= drop_r;
      out_read_valid_r     <= rv_r;
      out_read_symbol_r    <= rv_r ? fifo_q : 8'd0;
      out_fill_level_r     <= 6'(cnt_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_pattern    = out_key_pattern_r;
  assign out_symbol_made    = out_symbol_made_r;
  assign out_symbol_dropped = out_symbol_dropped_r;
  assign out_read_valid     = out_read_valid_r;
  assign out_read_symbol    = out_read_symbol_r;
  assign out_fill_level     = out_fill_level_r;

endmodule
